/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. The bodies are empty when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// cond must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

/* rtl/core/stsv_pkg.sv */
// ---------------------------------------------------------------------------
// stsv_pkg
// Types and constants shared by the token stream validator.
// ---------------------------------------------------------------------------
package stsv_pkg;

  // Stream phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_BODY    = 5'b00100,
    PH_ENDSEEN = 5'b01000,
    PH_ERROR   = 5'b10000
  } phase_t;

  // Event codes on the op field
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_TOKEN = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;
  localparam logic [1:0] OP_EMPTY = 2'd3;

  // Message codes
  localparam logic [3:0] MSG_BEGIN_ORDER = 4'd0;
  localparam logic [3:0] MSG_INSTR_ORDER = 4'd1;
  localparam logic [3:0] MSG_AFTER_END   = 4'd2;
  localparam logic [3:0] MSG_EMPTY       = 4'd3;
  localparam logic [3:0] MSG_VER_LEN     = 4'd4;
  localparam logic [3:0] MSG_VER_TYPE    = 4'd5;
  localparam logic [3:0] MSG_END_TOKEN   = 4'd6;
  localparam logic [3:0] MSG_END_ORDER   = 4'd7;
  localparam logic [3:0] MSG_MISSING_END = 4'd8;
  localparam logic [3:0] MSG_BAD_DCL     = 4'd9;
  localparam logic [3:0] MSG_BAD_INPUT   = 4'd10;

  // Register fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_DCL   = 2'd1;
  localparam logic [1:0] FAULT_OTHER = 2'd2;

  // Token field constants
  localparam logic [15:0] KIND_PIXEL  = 16'hffff;
  localparam logic [15:0] KIND_VERTEX = 16'hfffe;
  localparam logic [31:0] END_TOKEN   = 32'h0000ffff;
  localparam logic [15:0] OPC_COMMENT = 16'hfffe;
  localparam logic [15:0] OPC_DEF     = 16'h0051;
  localparam logic [15:0] OPC_DEFI    = 16'h0052;
  localparam logic [15:0] OPC_DEFB    = 16'h0053;
  localparam logic [15:0] OPC_DCL     = 16'h001f;
  localparam logic [4:0]  RTYPE_INPUT = 5'd1;

  localparam logic [10:0] LIMIT_RESET = 11'd10;

  typedef struct packed {
    phase_t      phase;
    logic        err_flag;
    logic        pixel_shader;
    logic [1:0]  group_count;
    logic [15:0] group_opcode;
    logic        head_kind_bad;
    logic        head_is_pixel;
    logic        head_is_end;
    logic        scan_active;
    logic [1:0]  register_fault;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:          PH_IDLE,
    err_flag:       1'b0,
    pixel_shader:   1'b0,
    group_count:    2'd0,
    group_opcode:   16'd0,
    head_kind_bad:  1'b0,
    head_is_pixel:  1'b0,
    head_is_end:    1'b0,
    scan_active:    1'b0,
    register_fault: FAULT_NONE
  };

  typedef struct packed {
    logic       is_status;
    logic [3:0] message;
    logic       failed;
    logic       last;
  } result_t;

  // Up to two messages and one status from one item
  typedef struct packed {
    result_t [2:0] item;
    logic [1:0]    count;
  } bundle_t;

endpackage

/* rtl/core/shader_token_stream_validator.sv */
// ---------------------------------------------------------------------------
// shader_token_stream_validator
// Checks a shader token stream and reports messages and a status per group or event.
// ---------------------------------------------------------------------------
// The block takes one stream item per transfer (begin, token, end or empty
// group) and judges it in the cycle it is accepted; its results show at the
// output from the next cycle on. Tokens that do not close a group produce
// nothing. An item that closes a group, or any begin/end/empty event, yields
// zero to two diagnostic message results followed by one status result
// (last = 1), one result per output transfer. Results sit in a three-entry
// output shift register; a new item is accepted when that register is empty
// or its final result is leaving in the same cycle. So an item with k results
// holds the output until all k have left, and the next item is taken as the
// final one leaves; tokens that only extend a group, and items with a single
// result while out_ready is high, run at one item per cycle.
// cfg_data sets the pixel shader input register limit (reset 10); it is
// always ready and is to be written only while the block is idle.
`include "assert_macros.svh"

module shader_token_stream_validator
  import stsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  // input stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] token,
  input  logic        group_first,
  input  logic        group_last,
  // result stream
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_status,
  output logic [3:0]  message,
  output logic        failed,
  output logic        last
);

  logic [10:0]   limit;
  state_t        st;
  state_t        st_next;
  bundle_t       bundle;
  result_t [2:0] res;       // res[0] faces the output
  logic [1:0]    cnt;       // results waiting
  logic          in_fire;
  logic          out_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit <= cfg_data;
    end
  end

  // Judge the incoming item against the current stream state
  stsv_step u_step (
    .st          (st),
    .limit       (limit),
    .op          (op),
    .token       (token),
    .group_first (group_first),
    .group_last  (group_last),
    .st_next     (st_next),
    .bundle      (bundle)
  );

  assign out_valid = (cnt != 2'd0);
  assign out_fire  = out_valid && out_ready;
  // Room when empty, or when the final waiting result leaves now
  assign in_ready  = (cnt == 2'd0) || (cnt == 2'd1 && out_ready);
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  // Output count: control, reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (in_fire && bundle.count != 2'd0) begin
      cnt <= bundle.count;
    end else if (out_fire) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Output payload: load a fresh bundle or shift toward the port
  always_ff @(posedge clk) begin
    if (in_fire && bundle.count != 2'd0) begin
      res <= bundle.item;
    end else if (out_fire) begin
      res[0] <= res[1];
      res[1] <= res[2];
    end
  end

  assign is_status = res[0].is_status;
  assign message   = res[0].message;
  assign failed    = res[0].failed;
  assign last      = res[0].last;

  // The status result is always the final result of its item
  `ASSERT_ALWAYS(a_last_is_status, clk, rst, out_valid |-> (last == is_status), "last and is_status disagree")
  // Message results never carry a fail flag
  `ASSERT_NEVER(a_msg_no_fail, clk, rst, out_valid && !is_status && failed, "message result with failed set")
  // Once a final result leaves with nothing new loaded, the output goes empty
  `ASSERT_ALWAYS(a_drain, clk, rst, (out_fire && last && !in_fire) |=> !out_valid, "results left after final transfer")

endmodule

/* rtl/core/stsv_step.sv */
// ---------------------------------------------------------------------------
// stsv_step
// Next-state and result logic for one stream item.
// ---------------------------------------------------------------------------
module stsv_step
  import stsv_pkg::*;
(
  input  state_t      st,
  input  logic [10:0] limit,
  input  logic [1:0]  op,
  input  logic [31:0] token,
  input  logic        group_first,
  input  logic        group_last,
  output state_t      st_next,
  output bundle_t     bundle
);

  state_t          s;
  logic [1:0]      nmsg;
  logic [1:0][3:0] msg;
  logic            emit;
  logic            fail;
  logic [15:0]     kind;
  logic [15:0]     opc;
  logic [4:0]      rtype;
  logic [10:0]     ridx;
  result_t         status;

  assign kind  = token[31:16];
  assign opc   = token[15:0];
  assign rtype = {token[12:11], token[30:28]};
  assign ridx  = token[10:0];

  always_comb begin
    s    = st;
    nmsg = 2'd0;
    msg  = '0;
    emit = 1'b1;
    fail = 1'b0;

    if (op == OP_TOKEN) begin
      if (group_first || st.group_count == 2'd0) begin
        // head token opens a group
        s.group_count    = 2'd1;
        s.group_opcode   = opc;
        s.head_kind_bad  = (kind != KIND_PIXEL) && (kind != KIND_VERTEX);
        s.head_is_pixel  = (kind == KIND_PIXEL);
        s.head_is_end    = (token == END_TOKEN);
        s.scan_active    = st.pixel_shader && opc != OPC_COMMENT && opc != OPC_DEF &&
                           opc != OPC_DEFI && opc != OPC_DEFB;
        s.register_fault = FAULT_NONE;
      end else begin
        if (st.group_count != 2'd2) s.group_count = st.group_count + 2'd1;
        if (st.scan_active) begin
          if (!token[31]) begin
            s.scan_active = 1'b0;
          end else if (rtype == RTYPE_INPUT && ridx >= limit) begin
            s.register_fault = (st.group_opcode == OPC_DCL) ? FAULT_DCL : FAULT_OTHER;
            s.scan_active    = 1'b0;
          end
        end
      end

      if (!group_last) begin
        emit = 1'b0;
      end else begin
        unique case (st.phase)
          PH_IDLE: begin
            msg[0] = MSG_INSTR_ORDER; nmsg = 2'd1; fail = 1'b1;
          end
          PH_ENDSEEN: begin
            msg[0] = MSG_AFTER_END; nmsg = 2'd1; fail = 1'b1;
          end
          PH_HEADER: begin
            if (s.group_count != 2'd1) begin
              msg[0] = MSG_VER_LEN;
              nmsg   = 2'd1;
            end
            if (s.head_kind_bad) begin
              msg[nmsg[0]] = MSG_VER_TYPE;
              nmsg         = nmsg + 2'd1;
            end
            if (nmsg != 2'd0) begin
              s.phase = PH_ERROR;
              fail    = 1'b1;
            end else begin
              s.pixel_shader = s.head_is_pixel;
              s.phase        = PH_BODY;
            end
          end
          PH_BODY: begin
            if (s.head_is_end) begin
              if (s.group_count != 2'd1) begin
                msg[0]  = MSG_END_TOKEN;
                nmsg    = 2'd1;
                s.phase = PH_ERROR;
                fail    = 1'b1;
              end else begin
                s.phase = PH_ENDSEEN;
              end
            end else if (s.register_fault == FAULT_DCL) begin
              msg[0] = MSG_BAD_DCL; nmsg = 2'd1;
            end else if (s.register_fault == FAULT_OTHER) begin
              msg[0] = MSG_BAD_INPUT; nmsg = 2'd1;
            end
          end
          default: fail = 1'b1;
        endcase
        s.group_count = 2'd0;
        s.scan_active = 1'b0;
      end
    end else begin
      // events drop any partial group
      s.group_count = 2'd0;
      s.scan_active = 1'b0;
      fail          = 1'b1;
      if (op == OP_EMPTY) begin
        msg[0] = MSG_EMPTY; nmsg = 2'd1;
      end else if (op == OP_BEGIN) begin
        if (st.phase != PH_IDLE) begin
          msg[0]  = MSG_BEGIN_ORDER; nmsg = 2'd1;
          s.phase = PH_ERROR;
        end else begin
          s.phase    = PH_HEADER;
          s.err_flag = 1'b0;
          fail       = 1'b0;
        end
      end else begin
        unique case (st.phase)
          PH_IDLE: begin
            msg[0] = MSG_END_ORDER; nmsg = 2'd1;
          end
          PH_HEADER, PH_BODY: begin
            msg[0]  = MSG_MISSING_END; nmsg = 2'd1;
            s.phase = PH_IDLE;
          end
          PH_ENDSEEN: begin
            fail       = st.err_flag;
            s.phase    = PH_IDLE;
            s.err_flag = 1'b0;
          end
          default: fail = 1'b1;
        endcase
      end
    end

    if (nmsg != 2'd0) s.err_flag = 1'b1;
  end

  assign st_next = s;

  always_comb begin
    status = '{is_status: 1'b1, message: MSG_BEGIN_ORDER, failed: fail, last: 1'b1};
    bundle = '0;
    if (emit) begin
      bundle.count = nmsg + 2'd1;
      unique case (nmsg)
        2'd0: begin
          bundle.item[0] = status;
        end
        2'd1: begin
          bundle.item[0] = '{is_status: 1'b0, message: msg[0], failed: 1'b0, last: 1'b0};
          bundle.item[1] = status;
        end
        default: begin
          bundle.item[0] = '{is_status: 1'b0, message: msg[0], failed: 1'b0, last: 1'b0};
          bundle.item[1] = '{is_status: 1'b0, message: msg[1], failed: 1'b0, last: 1'b0};
          bundle.item[2] = status;
        end
      endcase
    end
  end

endmodule
